FILE: hdl/text_console_writer_core_macros.svh
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define TCW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcw assertion failed");

// antecedent in one cycle implies consequent in the next
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT(lbl, clk, rst, prop)
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants shared by the text console writer modules
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int OP_W   = 2;
  localparam int CODE_W = 8;
  localparam int IDX_W  = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // interpreted character codes
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CODE_RETURN    = 8'h0D;
  localparam logic [CODE_W-1:0] GLYPH_RESET    = 8'd219;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_BACKSPACE,
    K_RETURN,
    K_READ,
    K_READ_ZERO,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  index;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw channel interfaces
// valid/ready channels for console commands and results
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::OP_W-1:0]     operation;
  logic [tcw_pkg::CODE_W-1:0]   char_code;
  logic [tcw_pkg::IDX_W-1:0]    cell_index;

  modport source (output valid, output operation, output char_code,
                  output cell_index, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input cell_index, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CODE_W-1:0]   cell_value;
  logic [tcw_pkg::IDX_W-1:0]    cursor_pos;

  modport source (output valid, output cell_value, output cursor_pos, input ready);
  modport sink   (input valid, input cell_value, input cursor_pos, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// accepts input transactions and classifies them into console commands
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 25
) (
  tcw_in_if.sink          in_ch,
  input  tcw_pkg::status_t status,
  input  logic            q_full,
  output logic            push,
  output tcw_pkg::cmd_t   push_cmd
);

  localparam int CELLS = COLUMNS * ROWS;

  assign in_ch.ready = !q_full && !status.init_busy;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_cmd.code  = in_ch.char_code;
    push_cmd.index = in_ch.cell_index;
    unique case (in_ch.operation)
      tcw_pkg::OP_PUT: begin
        unique case (in_ch.char_code)
          tcw_pkg::CODE_NEWLINE:   push_cmd.kind = tcw_pkg::K_NEWLINE;
          tcw_pkg::CODE_BACKSPACE: push_cmd.kind = tcw_pkg::K_BACKSPACE;
          tcw_pkg::CODE_RETURN:    push_cmd.kind = tcw_pkg::K_RETURN;
          default:                 push_cmd.kind = tcw_pkg::K_CHAR;
        endcase
      end
      tcw_pkg::OP_READ: begin
        // cells past the screen read as zero
        if (32'(in_ch.cell_index) < 32'(CELLS)) begin
          push_cmd.kind = tcw_pkg::K_READ;
        end else begin
          push_cmd.kind = tcw_pkg::K_READ_ZERO;
        end
      end
      tcw_pkg::OP_CLEAR: push_cmd.kind = tcw_pkg::K_CLEAR;
      default:           push_cmd.kind = tcw_pkg::K_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// short command fifo decoupling the front from the back
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tcw_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  tcw_pkg::cmd_t                  entries [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]     count;

  assign full    = (count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// screen memory sequencer: executes commands, scrolls, clears, reads cells
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_core_macros.svh"

module tcw_back #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tcw_pkg::CODE_W-1:0]   glyph,
  input  logic                         q_empty,
  input  tcw_pkg::cmd_t                cmd,
  output logic                         pop,
  output tcw_pkg::status_t             status,
  tcw_out_if.source                    out_ch
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int LAST_ROW = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(CELLS + 1);
  localparam int COLW     = $clog2(COLUMNS);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_BS2,
    S_CHECK,
    S_SCROLL_COPY,
    S_SCROLL_DRAIN,
    S_SCROLL_CLEAR,
    S_READ_WAIT,
    S_CLEAR
  } state_t;

  state_t                        state, state_next;
  logic [CW-1:0]                 cursor, cursor_next;
  logic [COLW-1:0]               col, col_next;
  logic [AW-1:0]                 cnt, cnt_next;
  logic                          cp_valid, cp_valid_next;
  logic [AW-1:0]                 cp_addr, cp_addr_next;
  logic                          out_valid;
  logic [tcw_pkg::CODE_W-1:0]    out_value;
  logic [tcw_pkg::IDX_W-1:0]     out_cursor;

  logic                          produce;
  logic [tcw_pkg::CODE_W-1:0]    prod_value;
  logic                          out_free;

  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;
  logic [tcw_pkg::CODE_W-1:0]    wdata, rd_data;
  logic [tcw_pkg::CODE_W-1:0]    screen [CELLS];

  assign out_free         = !out_valid || out_ch.ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.cell_value = out_value;
  assign out_ch.cursor_pos = out_cursor;
  assign status.init_busy  = (state == S_INIT);

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    col_next      = col;
    cnt_next      = cnt;
    cp_valid_next = 1'b0;
    cp_addr_next  = cnt;
    produce       = 1'b0;
    prod_value    = '0;
    pop           = 1'b0;
    re            = 1'b0;
    raddr         = '0;
    // pending scroll copy write, only ever set in the scroll states
    we            = cp_valid;
    waddr         = cp_addr;
    wdata         = rd_data;

    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = '0;
        if (cnt == AW'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          unique case (cmd.kind)
            tcw_pkg::K_CHAR: begin
              we          = 1'b1;
              waddr       = AW'(cursor);
              wdata       = cmd.code;
              cursor_next = cursor + 1'b1;
              col_next    = (col == COLW'(COLUMNS - 1)) ? '0 : col + 1'b1;
              state_next  = S_CHECK;
            end
            tcw_pkg::K_NEWLINE: begin
              we          = 1'b1;
              waddr       = AW'(cursor);
              wdata       = '0;
              cursor_next = cursor - CW'(col) + CW'(COLUMNS);
              col_next    = '0;
              state_next  = S_CHECK;
            end
            tcw_pkg::K_BACKSPACE: begin
              if (cursor != '0) begin
                we         = 1'b1;
                waddr      = AW'(cursor);
                wdata      = '0;
                state_next = S_BS2;
              end else begin
                state_next = S_CHECK;
              end
            end
            tcw_pkg::K_RETURN: begin
              state_next = S_CHECK;
            end
            tcw_pkg::K_READ: begin
              re         = 1'b1;
              raddr      = AW'(cmd.index);
              state_next = S_READ_WAIT;
            end
            tcw_pkg::K_READ_ZERO, tcw_pkg::K_NOP: begin
              produce = 1'b1;
            end
            tcw_pkg::K_CLEAR: begin
              cursor_next = '0;
              col_next    = '0;
              cnt_next    = '0;
              state_next  = S_CLEAR;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      S_BS2: begin
        we          = 1'b1;
        waddr       = AW'(cursor - 1'b1);
        wdata       = '0;
        cursor_next = cursor - 1'b1;
        col_next    = (col == '0) ? COLW'(COLUMNS - 1) : col - 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        if (cursor == CW'(CELLS)) begin
          // cursor ran off the screen: scroll up one row
          cnt_next   = '0;
          state_next = S_SCROLL_COPY;
        end else begin
          we         = 1'b1;
          waddr      = AW'(cursor);
          wdata      = glyph;
          produce    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCROLL_COPY: begin
        re            = 1'b1;
        raddr         = cnt + AW'(COLUMNS);
        cp_valid_next = 1'b1;
        cp_addr_next  = cnt;
        if (cnt == AW'(LAST_ROW - 1)) begin
          state_next = S_SCROLL_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCROLL_DRAIN: begin
        cnt_next   = AW'(LAST_ROW);
        state_next = S_SCROLL_CLEAR;
      end
      S_SCROLL_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = '0;
        if (cnt == AW'(CELLS - 1)) begin
          cursor_next = CW'(LAST_ROW);
          col_next    = '0;
          state_next  = S_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_READ_WAIT: begin
        produce    = 1'b1;
        prod_value = rd_data;
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = '0;
        if (cnt == AW'(CELLS - 1)) begin
          produce    = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // screen memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      screen[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= screen[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cursor    <= '0;
      col       <= '0;
      cnt       <= '0;
      cp_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      col      <= col_next;
      cnt      <= cnt_next;
      cp_valid <= cp_valid_next;
      if (produce) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
    cp_addr <= cp_addr_next;
    if (produce) begin
      out_value  <= prod_value;
      out_cursor <= tcw_pkg::IDX_W'(cursor);
    end
  end

  `TCW_ASSERT(a_cursor_on_screen, clk, rst, (state == S_IDLE) |-> (cursor < CW'(CELLS)))
  `TCW_ASSERT(a_col_range, clk, rst, col < COLW'(COLUMNS))
  `TCW_ASSERT(a_no_result_overwrite, clk, rst, produce |-> out_free)
  `TCW_ASSERT(a_copy_in_scroll, clk, rst, cp_valid |-> (state == S_SCROLL_COPY || state == S_SCROLL_DRAIN))
  `TCW_ASSERT_NEXT(a_scroll_cursor, clk, rst, (state == S_SCROLL_CLEAR && state_next == S_CHECK), cursor == CW'(LAST_ROW))

endmodule

`default_nettype wire

FILE: hdl/text_console_writer_core.sv
// Text console writer: keeps a COLUMNS x ROWS character screen in an on-chip
// memory and a write cursor, like a glass teletype. Commands come in on in_ch
// (put character, read cell, clear) and every command gives exactly one
// result on out_ch: the read byte (zero for other commands) and the cursor
// afterwards. Each command is held in the queue after its transaction. After
// leaving the queue, a put of an ordinary character, newline or carriage
// return passes through S_CHECK, which writes the cursor glyph and registers
// the result; a backspace that erases goes through S_BS2 first, since the
// screen memory has a single write port; a read of a screen cell waits in
// S_READ_WAIT for the registered read port; a read past the screen or an
// unused operation is answered straight from idle. A put that runs off the
// last cell scrolls the screen through that same port pair. A clear sweeps
// the memory once. After reset the screen memory is zeroed by a pass over
// every cell, during which in_ch.ready stays low; configuration writes are
// taken at any time. The cursor glyph register lives at APB byte address 0.
// ----------------------------------------------------------------------------
// text_console_writer_core
// top level: apb config, command front, queue, screen back end
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  tcw_in_if.sink      in_ch,
  tcw_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // cursor glyph register
  logic [tcw_pkg::CODE_W-1:0] glyph;
  logic                       cfg_sel;
  logic                       cfg_write;

  // front to queue
  logic             q_push;
  tcw_pkg::cmd_t    q_push_cmd;
  logic             q_full;

  // queue to back
  logic             q_pop;
  tcw_pkg::cmd_t    q_pop_cmd;
  logic             q_empty;

  tcw_pkg::status_t status;

  // register 0 is the only one; other word addresses read zero
  assign cfg_sel   = ((paddr >> 2) == 3'd0);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = cfg_sel ? {24'd0, glyph} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph <= tcw_pkg::GLYPH_RESET;
    end else if (cfg_write && cfg_sel) begin
      glyph <= pwdata[tcw_pkg::CODE_W-1:0];
    end
  end

  // front: take a transaction and classify it into a command
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_ch    (in_ch),
    .status   (status),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  // short queue so the front keeps accepting while the back works
  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: screen memory sequencer and result register
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .glyph   (glyph),
    .q_empty (q_empty),
    .cmd     (q_pop_cmd),
    .pop     (q_pop),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: test/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// drives put, read, clear and unused commands into the text console writer,
// keeps a shadow copy of the screen, cursor and glyph register, and checks
// every result transaction field by field against that shadow copy
// ----------------------------------------------------------------------------

module tb_text_console_writer_core;

  // field widths
  localparam int OP_W   = tcw_pkg::OP_W;
  localparam int CODE_W = tcw_pkg::CODE_W;
  localparam int IDX_W  = tcw_pkg::IDX_W;

  // screen geometry, matches the block defaults
  localparam int COLUMNS        = 40;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

  // operation code the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // register map
  localparam logic [2:0] ADDR_CURSOR_GLYPH = 3'd0;

  // a scroll is the slowest command
  localparam int SETTLE_CYCLES    = 16;
  localparam int END_QUIET_CYCLES = 1100;
  localparam int RX_STALL_CYCLES  = 400;
  // slowest run: every command a scroll plus the longest stalls, taken several times
  localparam int LIMIT_CYCLES     = 5_000_000;

  typedef struct packed {
    logic [CODE_W-1:0] cell_value;
    logic [IDX_W-1:0]  cursor_pos;
  } console_readout_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow state of the console
  logic [CODE_W-1:0] screen_image [CELLS];
  int unsigned       cursor_image;
  logic [CODE_W-1:0] glyph_image;

  // results still owed by the block, oldest first
  console_readout_t console_readouts [$];

  // idle percentages for each side
  int tx_idle_pct;
  int rx_idle_pct;

  // long receiver hold-off request, counted down in the receiver process
  logic rx_stall_go;
  int   rx_stall_left;

  int error_count;
  int results_checked;
  int cycle_count;
  int scroll_count;
  int op_count [4];

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               console_readouts.size());
      $display("text_console_writer_core verification failed");
      $finish;
    end
  end

  // result receiver: random idling, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready  <= 1'b0;
      rx_stall_left <= 0;
    end else if (rx_stall_go) begin
      out_ch.ready  <= 1'b0;
      rx_stall_left <= RX_STALL_CYCLES;
    end else if (rx_stall_left != 0) begin
      out_ch.ready  <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker: each accepted result against the oldest one owed
  always @(posedge clk) begin
    console_readout_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (console_readouts.size() == 0) begin
        $display("%0t: result with nothing owed, cell_value %0d cursor_pos %0d", $time,
                 out_ch.cell_value, out_ch.cursor_pos);
        error_count++;
      end else begin
        want = console_readouts.pop_front();
        results_checked++;
        if (out_ch.cell_value !== want.cell_value) begin
          $display("%0t: cell_value mismatch, expected %0d actual %0d", $time,
                   want.cell_value, out_ch.cell_value);
          error_count++;
        end
        if (out_ch.cursor_pos !== want.cursor_pos) begin
          $display("%0t: cursor_pos mismatch, expected %0d actual %0d", $time,
                   want.cursor_pos, out_ch.cursor_pos);
          error_count++;
        end
      end
    end
  end

  // advance the shadow console by one command and work out its result
  function automatic console_readout_t console_apply(input logic [OP_W-1:0] op,
                                                     input logic [CODE_W-1:0] code,
                                                     input logic [IDX_W-1:0] idx);
    console_readout_t res;
    res.cell_value = '0;
    if (cursor_image >= CELLS) cursor_image = 0;
    op_count[op]++;
    case (op)
      tcw_pkg::OP_PUT: begin
        if (code == tcw_pkg::CODE_NEWLINE) begin
          screen_image[cursor_image] = '0;
          cursor_image = (cursor_image / COLUMNS + 1) * COLUMNS;
        end else if (code == tcw_pkg::CODE_BACKSPACE) begin
          // backspace at the home cell changes nothing
          if (cursor_image > 0) begin
            screen_image[cursor_image]     = '0;
            screen_image[cursor_image - 1] = '0;
            cursor_image--;
          end
        end else if (code != tcw_pkg::CODE_RETURN) begin
          screen_image[cursor_image] = code;
          cursor_image++;
        end
        // ran off the last cell: every row moves up, last row blank
        if (cursor_image >= CELLS) begin
          for (int i = 0; i < LAST_ROW_START; i++) screen_image[i] = screen_image[i + COLUMNS];
          for (int i = LAST_ROW_START; i < CELLS; i++) screen_image[i] = '0;
          cursor_image = LAST_ROW_START;
          scroll_count++;
        end
        screen_image[cursor_image] = glyph_image;
      end
      tcw_pkg::OP_READ: begin
        // cells past the screen read as zero
        if (idx < CELLS) res.cell_value = screen_image[idx];
      end
      tcw_pkg::OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_image[i] = '0;
        cursor_image = 0;
      end
      default: begin
      end
    endcase
    res.cursor_pos = cursor_image[IDX_W-1:0];
    return res;
  endfunction

  // offer one command after a random gap, wait for the transaction, then
  // record what it must produce; valid stays high for a back-to-back command
  task automatic send_command(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                              input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.char_code  <= code;
    in_ch.cell_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    console_readouts.push_back(console_apply(op, code, idx));
  endtask

  // sender pauses until every owed result is in and the block is quiet
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (console_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb read: setup cycle then access cycle
  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_glyph_register();
    logic [31:0] readback;
    apb_read(ADDR_CURSOR_GLYPH, readback);
    if (readback[CODE_W-1:0] !== glyph_image) begin
      $display("%0t: cursor_glyph readback mismatch, expected %0d actual %0d", $time,
               glyph_image, readback[CODE_W-1:0]);
      error_count++;
    end
  endtask

  // glyph register write, only with the block idle, then read back
  task automatic write_glyph(input logic [CODE_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CURSOR_GLYPH;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    glyph_image = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_glyph_register();
  endtask

  // field extremes, every operation and the odd cases, at the reset glyph
  task automatic test_directed_cases();
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, '0);  // backspace at the home cell
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_RETURN, '0);     // carriage return, glyph only
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd0);
    send_command(tcw_pkg::OP_PUT, 8'hFF, 10'h3FF);
    send_command(tcw_pkg::OP_PUT, 8'h00, 10'd0);
    send_command(tcw_pkg::OP_PUT, 8'h7F, 10'd0);
    send_command(tcw_pkg::OP_PUT, 8'h80, 10'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, '0);  // backspace with cells to erase
    send_command(tcw_pkg::OP_READ, 8'hFF, 10'd1);
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd2);
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd3);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_NEWLINE, '0);
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd40);
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd999);     // last real cell
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd1000);    // first cell past the screen
    send_command(tcw_pkg::OP_READ, 8'hFF, 10'h3FF);     // far past the screen
    send_command(OP_UNUSED, 8'hFF, 10'h3FF);
    send_command(OP_UNUSED, 8'h00, 10'd0);
    send_command(tcw_pkg::OP_CLEAR, 8'h5A, 10'd500);
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd0);
    send_command(tcw_pkg::OP_PUT, 8'h41, 10'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 10'd0);
  endtask

  // text made of lines of random length and content, with reads scattered
  // through it; clears are rare so the screen fills and scrolls often
  task automatic run_text_traffic(input int n_items);
    int sel;
    int line_left;
    int near;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  idx;
    line_left = $urandom_range(60);
    for (int n = 0; n < n_items; n++) begin
      sel  = $urandom_range(999);
      code = CODE_W'($urandom_range(255));
      idx  = IDX_W'($urandom_range(1023));
      if (sel < 2) begin
        send_command(tcw_pkg::OP_CLEAR, code, idx);
      end else if (sel < 12) begin
        send_command(OP_UNUSED, code, idx);
      end else if (sel < 212) begin
        // reads: anywhere, past the screen, or just around the cursor
        sel = $urandom_range(9);
        if (sel < 5) begin
          idx = IDX_W'($urandom_range(CELLS - 1));
        end else if (sel < 6) begin
          idx = IDX_W'($urandom_range(1023, CELLS));
        end else begin
          near = int'(cursor_image) - int'($urandom_range(3));
          idx  = (near < 0) ? 10'd0 : near[IDX_W-1:0];
        end
        send_command(tcw_pkg::OP_READ, code, idx);
      end else if (line_left == 0) begin
        send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_NEWLINE, idx);
        // now and then a line long enough to wrap a row
        line_left = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(35);
      end else begin
        sel = $urandom_range(99);
        if (sel < 88) code = CODE_W'($urandom_range(126, 32));
        else if (sel < 93) code = tcw_pkg::CODE_BACKSPACE;
        else if (sel < 95) code = tcw_pkg::CODE_RETURN;
        send_command(tcw_pkg::OP_PUT, code, idx);
        line_left--;
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the command
  // queue fills and the block drops ready; then the sender waits it out
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_stall_go <= 1'b1;
    @(posedge clk);
    rx_stall_go <= 1'b0;
    run_text_traffic(30);
    drain_results();
  endtask

  initial begin
    // every input known from the start
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = tcw_pkg::OP_PUT;
    in_ch.char_code  = '0;
    in_ch.cell_index = '0;
    out_ch.ready     = 1'b0;
    rx_stall_go      = 1'b0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    error_count      = 0;
    results_checked  = 0;
    cycle_count      = 0;
    scroll_count     = 0;
    op_count         = '{default: 0};
    for (int i = 0; i < CELLS; i++) screen_image[i] = '0;
    cursor_image = 0;
    glyph_image  = tcw_pkg::GLYPH_RESET;

    // single reset at the start; the block then clears its memory with ready low
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // glyph register must come up at its reset value
    check_glyph_register();

    tx_idle_pct = 37;
    rx_idle_pct = 80;
    test_directed_cases();

    // random text at the glyph extremes and at a random glyph, with both
    // idling patterns and then full speed
    write_glyph(8'h00);
    run_text_traffic(400);

    write_glyph(8'hFF);
    tx_idle_pct = 80;
    rx_idle_pct = 37;
    run_text_traffic(400);

    write_glyph(CODE_W'($urandom_range(255)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_text_traffic(400);

    write_glyph(tcw_pkg::GLYPH_RESET);
    test_output_stall();

    // nothing owed any more; watch for stray results a scroll's time longer
    drain_results();
    repeat (END_QUIET_CYCLES) @(posedge clk);

    $display("ran %0d puts, %0d reads, %0d clears, %0d unused commands; %0d scrolls",
             op_count[tcw_pkg::OP_PUT], op_count[tcw_pkg::OP_READ],
             op_count[tcw_pkg::OP_CLEAR], op_count[OP_UNUSED], scroll_count);
    $display("%0d results checked under both idling patterns and a long output stall, %0d errors",
             results_checked, error_count);
    if (error_count == 0 && console_readouts.size() == 0) begin
      $display("text_console_writer_core verification clean");
    end else begin
      $display("text_console_writer_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer_core.sv
test/tb_text_console_writer_core.sv
